// File: sv/ttsc_pkg.sv
// Shared types, constants and codes of the touch three-point scale calibrator.
package ttsc_pkg;

    // Field widths fixed by the item formats.
    localparam int COORD_W   = 16;
    localparam int SCALE_W   = 28;
    localparam int STAGE_W   = 3;
    localparam int CNT_W     = 3;
    localparam int SPAN_W    = 16;
    localparam int NUM_CAL_POINTS = 3;
    localparam int SLOT_W    = $clog2(NUM_CAL_POINTS);

    // Default number of fraction bits in the scale factors.
    localparam int FRAC_BITS_DEF = 16;

    // Largest scale factor and coordinate.
    localparam logic [SCALE_W-1:0] SCALE_MAX = {SCALE_W{1'b1}};
    localparam logic [COORD_W-1:0] COORD_MAX = {COORD_W{1'b1}};

    // Calibration stages.
    localparam logic [STAGE_W-1:0] STAGE_OFF   = 3'd0;
    localparam logic [STAGE_W-1:0] STAGE_FIRST = 3'd1;
    localparam logic [STAGE_W-1:0] STAGE_LAST  = 3'd6;

    // Configuration register indexes and their reset value.
    localparam logic REG_LMAX_X = 1'b0;
    localparam logic REG_LMAX_Y = 1'b1;
    localparam logic [SPAN_W-1:0] LOGICAL_MAX_RST = 16'd2047;

    // APB widths.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Input item as it arrives on the port.
    typedef struct packed {
        logic               action;
        logic [CNT_W-1:0]   contacts;
        logic [CNT_W-1:0]   point_index;
        logic [COORD_W-1:0] x_in;
        logic [COORD_W-1:0] y_in;
    } t_item;

    // Result item as it leaves the block.
    typedef struct packed {
        logic [COORD_W-1:0] x_out;
        logic [COORD_W-1:0] y_out;
        logic               passed;
        logic               led_on;
        logic [STAGE_W-1:0] stage;
    } t_result;

    // Item classes decided by the front end.
    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_LEAD,
        CMD_OTHER
    } t_cmd_kind;

    // Classified item handed from the front end to the back end.
    typedef struct packed {
        t_cmd_kind          kind;
        logic               pressed;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_cmd;

    // Back end sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV_X,
        ST_DIV_Y,
        ST_PUSH
    } t_back_state;

endpackage

// File: sv/ttsc_queue.sv
// Two-entry first-in first-out queue built from flip-flops.
module ttsc_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;
    logic         do_push;
    logic         do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// File: sv/ttsc_front.sv
// Front end: input register that accepts items and classifies them.
module ttsc_front
    import ttsc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  push,
    output logic  full,
    input  t_item i_item,
    output logic  o_q_push,
    output t_cmd  o_cmd,
    input  logic  i_q_full
);

    logic r_valid;
    t_cmd r_cmd;
    t_cmd cls;
    logic take;

    // Ticks, the lead contact and the remaining contacts go separate ways.
    always_comb begin
        cls.pressed = (i_item.contacts != '0);
        cls.x       = i_item.x_in;
        cls.y       = i_item.y_in;
        if (i_item.action) begin
            cls.kind = CMD_TICK;
        end else if (i_item.point_index == '0) begin
            cls.kind = CMD_LEAD;
        end else begin
            cls.kind = CMD_OTHER;
        end
    end

    // The register drains into the queue whenever the queue has room.
    assign full     = r_valid && i_q_full;
    assign take     = push && !full;
    assign o_q_push = r_valid;
    assign o_cmd    = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (!i_q_full) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd <= cls;
        end
    end

endmodule

// File: sv/ttsc_div.sv
// Restoring divider that produces one quotient bit per cycle.
module ttsc_div
    import ttsc_pkg::*;
#(
    parameter int DW = SPAN_W + FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DW-1:0]     i_dividend,
    input  logic [SPAN_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DW-1:0]     o_quotient
);

    localparam int CW = $clog2(DW);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [DW-1:0]     r_quo;
    logic [SPAN_W-1:0] r_rem;
    logic [SPAN_W-1:0] r_div;
    logic [SPAN_W:0]   rem_sh;
    logic [SPAN_W:0]   rem_sub;
    logic              ge;

    // One trial subtraction per cycle.
    assign rem_sh  = {r_rem, r_quo[DW-1]};
    assign ge      = (rem_sh >= {1'b0, r_div});
    assign rem_sub = rem_sh - {1'b0, r_div};

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    // Control: the count runs once over all dividend bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CW'(1);
            if (r_cnt == CW'(DW - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // Datapath: the quotient shifts in where the dividend shifts out.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[SPAN_W-1:0] : rem_sh[SPAN_W-1:0];
            r_quo <= {r_quo[DW-2:0], ge};
        end
    end

endmodule

// File: sv/ttsc_back.sv
// Back end: calibration stage machine, coordinate scaling and scale update.
module ttsc_back
    import ttsc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [SPAN_W-1:0] i_lmax_x,
    input  logic [SPAN_W-1:0] i_lmax_y,
    input  t_cmd              i_cmd,
    input  logic              i_cmd_empty,
    output logic              o_cmd_pop,
    output logic              o_res_push,
    output t_result           o_res,
    input  logic              i_res_full
);

    localparam int DW = SPAN_W + FRAC_BITS;
    localparam int QW = (DW > SCALE_W) ? DW : SCALE_W;
    localparam int PW = COORD_W + SCALE_W;
    localparam logic [SCALE_W-1:0] X_SCALE_RST = SCALE_W'(longint'(2) << FRAC_BITS);
    localparam logic [SCALE_W-1:0] Y_SCALE_RST =
        SCALE_W'(((longint'(341) << FRAC_BITS) + 50) / 100);

    t_back_state        r_state, n_state;
    logic [STAGE_W-1:0] r_stage, n_stage;
    logic               r_led, n_led;
    t_result            r_res, n_res;
    logic [SCALE_W-1:0] r_x_scale;
    logic [SCALE_W-1:0] r_y_scale;
    logic [COORD_W-1:0] r_cap_x [NUM_CAL_POINTS];
    logic [COORD_W-1:0] r_cap_y [NUM_CAL_POINTS];
    logic [PW-1:0]      r_px;
    logic [PW-1:0]      r_py;
    logic [SPAN_W-1:0]  r_dy;
    logic               r_zero_x;
    logic               r_zero_y;

    logic               mul_load;
    logic               cap_we;
    logic               end_start;
    logic               end_x;
    logic               end_y;
    logic               div_start;
    logic [DW-1:0]      div_dividend;
    logic [SPAN_W-1:0]  div_divisor;
    logic               div_done;
    logic [DW-1:0]      div_quo;
    logic [QW-1:0]      quo_ext;
    logic [SCALE_W-1:0] quo_sat;
    logic [STAGE_W-1:0] stage_m1;
    logic [SLOT_W-1:0]  slot;
    logic [SPAN_W-1:0]  dx;
    logic [SPAN_W-1:0]  dy;
    logic [PW-1:0]      px_sh;
    logic [PW-1:0]      py_sh;
    logic [COORD_W-1:0] x_sat;
    logic [COORD_W-1:0] y_sat;

    ttsc_div #(
        .DW (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Captured point slot for the current stage: stages 1 and 2 use slot 0, and so on.
    assign stage_m1 = r_stage - STAGE_FIRST;
    assign slot     = stage_m1[SLOT_W:1];

    // Distances between captured points.
    assign dx = (r_cap_x[0] > r_cap_x[1]) ? r_cap_x[0] - r_cap_x[1] : r_cap_x[1] - r_cap_x[0];
    assign dy = (r_cap_y[1] > r_cap_y[2]) ? r_cap_y[1] - r_cap_y[2] : r_cap_y[2] - r_cap_y[1];

    // Quotient saturation, also for a zero distance.
    assign quo_ext = QW'(div_quo);
    always_comb begin
        if ((end_x && r_zero_x) || (end_y && r_zero_y) || (quo_ext > QW'(SCALE_MAX))) begin
            quo_sat = SCALE_MAX;
        end else begin
            quo_sat = quo_ext[SCALE_W-1:0];
        end
    end

    // Truncate and saturate the registered products.
    assign px_sh = r_px >> FRAC_BITS;
    assign py_sh = r_py >> FRAC_BITS;
    assign x_sat = (px_sh[PW-1:COORD_W] != '0) ? COORD_MAX : px_sh[COORD_W-1:0];
    assign y_sat = (py_sh[PW-1:COORD_W] != '0) ? COORD_MAX : py_sh[COORD_W-1:0];

    assign o_res = r_res;

    // Sequencer: next state and control.
    always_comb begin
        n_state      = r_state;
        n_stage      = r_stage;
        n_led        = r_led;
        n_res        = r_res;
        o_cmd_pop    = 1'b0;
        o_res_push   = 1'b0;
        mul_load     = 1'b0;
        cap_we       = 1'b0;
        end_start    = 1'b0;
        end_x        = 1'b0;
        end_y        = 1'b0;
        div_start    = 1'b0;
        div_dividend = {i_lmax_x, {FRAC_BITS{1'b0}}};
        div_divisor  = dx;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    n_state   = ST_PUSH;
                    priority if (i_cmd.kind == CMD_TICK) begin
                        if (r_stage == STAGE_OFF) begin
                            n_stage = STAGE_FIRST;
                            n_led   = 1'b0;
                        end
                    end else if (r_stage == STAGE_OFF) begin
                        mul_load = 1'b1;
                        n_state  = ST_MUL;
                    end else if (i_cmd.kind == CMD_LEAD) begin
                        n_led = i_cmd.pressed;
                        if (r_stage[0]) begin
                            if (i_cmd.pressed) begin
                                cap_we  = 1'b1;
                                n_stage = r_stage + STAGE_W'(1);
                            end
                        end else if (i_cmd.pressed) begin
                            cap_we = 1'b1;
                        end else if (r_stage >= STAGE_LAST) begin
                            end_start = 1'b1;
                            div_start = 1'b1;
                            n_state   = ST_DIV_X;
                        end else begin
                            n_stage = r_stage + STAGE_W'(1);
                        end
                    end else begin
                        // Other contacts during calibration leave stage and LED alone.
                        n_stage = r_stage;
                    end
                    n_res.x_out  = '0;
                    n_res.y_out  = '0;
                    n_res.passed = 1'b0;
                    n_res.led_on = n_led;
                    n_res.stage  = n_stage;
                end
            end
            ST_MUL: begin
                n_res.x_out  = x_sat;
                n_res.y_out  = y_sat;
                n_res.passed = 1'b1;
                n_res.led_on = r_led;
                n_res.stage  = r_stage;
                n_state      = ST_PUSH;
            end
            ST_DIV_X: begin
                if (div_done) begin
                    end_x        = 1'b1;
                    div_start    = 1'b1;
                    div_dividend = {i_lmax_y, {FRAC_BITS{1'b0}}};
                    div_divisor  = r_dy;
                    n_state      = ST_DIV_Y;
                end
            end
            ST_DIV_Y: begin
                if (div_done) begin
                    end_y        = 1'b1;
                    n_led        = 1'b1;
                    n_stage      = STAGE_OFF;
                    n_res.x_out  = '0;
                    n_res.y_out  = '0;
                    n_res.passed = 1'b0;
                    n_res.led_on = 1'b1;
                    n_res.stage  = STAGE_OFF;
                    n_state      = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_stage   <= STAGE_OFF;
            r_led     <= 1'b1;
            r_x_scale <= X_SCALE_RST;
            r_y_scale <= Y_SCALE_RST;
        end else begin
            r_state <= n_state;
            r_stage <= n_stage;
            r_led   <= n_led;
            if (end_x) begin
                r_x_scale <= quo_sat;
            end
            if (end_y) begin
                r_y_scale <= quo_sat;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (mul_load) begin
            r_px <= PW'(i_cmd.x) * PW'(r_x_scale);
            r_py <= PW'(i_cmd.y) * PW'(r_y_scale);
        end
        if (cap_we) begin
            r_cap_x[slot] <= i_cmd.x;
            r_cap_y[slot] <= i_cmd.y;
        end
        if (end_start) begin
            r_dy     <= dy;
            r_zero_x <= (dx == '0);
            r_zero_y <= (dy == '0);
        end
    end

endmodule

// File: sv/touch_three_point_scale_calibrator_core.sv
// Touch calibrator top level: register port, front end, queues and back end.
//
// Each accepted item yields exactly one result. A contact item while idle is
// scaled by the current factors and passed; ticks and contacts during
// calibration are swallowed. From push to result an item passes through the
// front register, the command queue, a decode step in the back end, a
// multiply step for scaled points, and the result register. The release
// that ends calibration also runs two divisions, x and then y, on the shared
// one-bit-per-cycle divider. The back end handles one item at a time; the
// two-entry queues on either side let the front keep taking items and the
// consumer keep draining results while it works. The user must write the
// logical spans over the APB port at byte addresses 0 (x) and 4 (y) only
// while idle; the block itself does not enforce this.
module touch_three_point_scale_calibrator_core
    import ttsc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  t_item             i_item,
    output logic              empty,
    input  logic              pop,
    output t_result           o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [SPAN_W-1:0] r_lmax_x;
    logic [SPAN_W-1:0] r_lmax_y;
    logic              cfg_wr;
    logic              reg_sel;

    logic              cq_push;
    t_cmd              cq_in;
    logic              cq_full;
    logic              cq_pop;
    logic [$bits(t_cmd)-1:0] cq_out;
    logic              cq_empty;
    logic              rq_push;
    t_result           rq_in;
    logic              rq_full;
    logic [$bits(t_result)-1:0] rq_out;

    // Register port: each write transfer completes in its access cycle.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lmax_x <= LOGICAL_MAX_RST;
            r_lmax_y <= LOGICAL_MAX_RST;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_LMAX_X: r_lmax_x <= pwdata[SPAN_W-1:0];
                REG_LMAX_Y: r_lmax_y <= pwdata[SPAN_W-1:0];
                default:    r_lmax_x <= r_lmax_x;
            endcase
        end
    end

    // Read back the selected span.
    always_comb begin
        unique case (reg_sel)
            REG_LMAX_X: prdata = APB_DW'(r_lmax_x);
            REG_LMAX_Y: prdata = APB_DW'(r_lmax_y);
            default:    prdata = '0;
        endcase
    end

    ttsc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .o_q_push (cq_push),
        .o_cmd    (cq_in),
        .i_q_full (cq_full)
    );

    ttsc_queue #(
        .W ($bits(t_cmd))
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cq_push),
        .i_data  (cq_in),
        .o_full  (cq_full),
        .i_pop   (cq_pop),
        .o_data  (cq_out),
        .o_empty (cq_empty)
    );

    ttsc_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_lmax_x    (r_lmax_x),
        .i_lmax_y    (r_lmax_y),
        .i_cmd       (t_cmd'(cq_out)),
        .i_cmd_empty (cq_empty),
        .o_cmd_pop   (cq_pop),
        .o_res_push  (rq_push),
        .o_res       (rq_in),
        .i_res_full  (rq_full)
    );

    ttsc_queue #(
        .W ($bits(t_result))
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rq_push),
        .i_data  (rq_in),
        .o_full  (rq_full),
        .i_pop   (pop),
        .o_data  (rq_out),
        .o_empty (empty)
    );

    assign o_result = t_result'(rq_out);

endmodule
